// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, codes and the link record that passes between queue cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default number of entries held by the queue.
  localparam int SPQ_CAPACITY = 16;

  // Field widths of the stream words.
  localparam int DATA_W  = 32;
  localparam int OCC_W   = 5;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;

  // Command codes carried in the input tuser.
  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } spq_cmd_t;

  // Status codes carried in the output tuser.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } spq_status_t;

  // What one cell shows to its neighbours.
  typedef struct packed {
    logic                     valid;
    logic                     keep;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] prio;
  } spq_link_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] prio;
  } spq_op_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry. On insert it keeps its entry, takes the new one or takes
// the entry of the cell above; on remove it takes the entry of the cell below.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::spq_op_t   op,
  input  spq_pkg::spq_link_t left,
  input  spq_pkg::spq_link_t right,
  output spq_pkg::spq_link_t link
);
  import spq_pkg::*;

  logic                     valid;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] prio;
  logic                     keep;

  // An entry stays put when it is ahead of the new one (ties keep arrival order).
  assign keep = valid && (prio >= op.prio);

  assign link.valid = valid;
  assign link.keep  = keep;
  assign link.val   = val;
  assign link.prio  = prio;

  // Occupancy flag of this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.ins && !keep) begin
      valid <= left.keep ? 1'b1 : left.valid;
    end else if (op.rem) begin
      valid <= right.valid;
    end
  end

  // Entry payload, which needs no reset.
  always_ff @(posedge clk) begin
    if (op.ins && !keep) begin
      if (left.keep) begin
        val  <= op.val;
        prio <= op.prio;
      end else begin
        val  <= left.val;
        prio <= left.prio;
      end
    end else if (op.rem) begin
      val  <= right.val;
      prio <= right.prio;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// The result word is registered at the edge that accepts its input word.
// Throughput: one word per cycle while the result is not stalled; every cell compares and shifts in the same cycle.
// The output register takes the next result whenever it is empty or being drained.
// Reset (synchronous, active high) clears the cell valid flags, the entry count and
// the output valid flag at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Sorted priority queue core
// A chain of cells kept sorted by descending priority, with a result register.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: item_value[31:0], item_priority[63:32].
  input  logic [spq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: command[0].
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: removed_value[31:0], removed_priority[63:32],
  // occupancy[68:64], zero padding[71:69].
  output logic [spq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]                       m_axis_tuser
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                   accept;
  logic                   is_full;
  logic                   is_empty;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [31:0]            count_ext;
  spq_op_t                op;
  spq_link_t              links [CAPACITY];
  spq_link_t              head_left;
  spq_link_t              tail_right;
  spq_status_t            status_next;
  logic [OUT_TDATA_W-1:0] tdata_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_full       = (count == CNT_W'(CAPACITY));
  assign is_empty      = (count == '0);

  // Operation broadcast; error cases leave the chain untouched.
  assign op.ins  = accept && (spq_cmd_t'(s_axis_tuser) == CMD_INSERT) && !is_full;
  assign op.rem  = accept && (spq_cmd_t'(s_axis_tuser) == CMD_REMOVE) && !is_empty;
  assign op.val  = s_axis_tdata[DATA_W-1:0];
  assign op.prio = s_axis_tdata[2*DATA_W-1:DATA_W];

  // Boundaries of the chain: above the head everything is kept, below the tail is empty.
  assign head_left  = '{valid: 1'b1, keep: 1'b1, val: '0, prio: '0};
  assign tail_right = '{valid: 1'b0, keep: 1'b0, val: '0, prio: '0};

  // The row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .op    (op),
        .left  (head_left),
        .right ((CAPACITY > 1) ? links[(i + 1) % CAPACITY] : tail_right),
        .link  (links[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      spq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .op    (op),
        .left  (links[i - 1]),
        .right (tail_right),
        .link  (links[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .op    (op),
        .left  (links[i - 1]),
        .right (links[i + 1]),
        .link  (links[i])
      );
    end
  end

  // Entry count and status of the current word.
  always_comb begin
    count_next  = count;
    status_next = STATUS_OK;
    if (op.ins) begin
      count_next = count + 1'b1;
    end else if (op.rem) begin
      count_next = count - 1'b1;
    end
    if (spq_cmd_t'(s_axis_tuser) == CMD_INSERT) begin
      if (is_full) status_next = STATUS_FULL;
    end else begin
      if (is_empty) status_next = STATUS_EMPTY;
    end
  end

  assign count_ext = 32'(count_next);

  // Result payload: the occupancy always, and the head entry on a remove; the entry fields are zero otherwise.
  always_comb begin
    tdata_next = '0;
    tdata_next[2*DATA_W+OCC_W-1:2*DATA_W] = count_ext[OCC_W-1:0];
    if (op.rem) begin
      tdata_next[DATA_W-1:0]        = links[0].val;
      tdata_next[2*DATA_W-1:DATA_W] = links[0].prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register: valid flag under reset, payload loaded on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser <= status_next;
      m_axis_tdata <= tdata_next;
    end
  end

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level properties of the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);
  import spq_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Input is only held off by a stalled result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending result");

  // Error words carry no entry.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> m_axis_tdata[2*DATA_W-1:0] == '0)
    else $error("error word carries entry data");

  // An empty error reports no entries, a full error reports capacity.
  a_err_occ: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tuser != STATUS_EMPTY) ||
       (m_axis_tdata[2*DATA_W+OCC_W-1:2*DATA_W] == '0)) &&
      ((m_axis_tuser != STATUS_FULL) ||
       (m_axis_tdata[2*DATA_W+OCC_W-1:2*DATA_W] == OCC_W'(CAPACITY))))
    else $error("occupancy disagrees with error status");

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
